// ===== hw/rtl/svq_pkg.sv =====
// ----------------------------------------------------------------------------
// svq_pkg: shared definitions of the split virtqueue descriptor manager
// Operation and status codes, the input word record and configuration control.
// ----------------------------------------------------------------------------
package svq_pkg;

	localparam int QUEUE_DEPTH_DEF = 256;

	localparam logic [3:0] QLOG2_RESET = 4'd8;

	// Operation codes carried on tuser
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_POST = 2'd1;
	localparam logic [1:0] OP_GET  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;

	// Register index of queue_size_log2
	localparam logic REG_QLOG2 = 1'b0;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] buf_addr;
		logic [31:0] buf_len;
		logic        buf_write;
		logic [8:0]  chain_length;
		logic        chain_last;
		logic [63:0] chain_token;
		logic [7:0]  used_id;
		logic [31:0] used_len;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  desc_index;
		logic [1:0]  desc_flags;
		logic [7:0]  avail_slot;
		logic [15:0] avail_index;
		logic [63:0] token_out;
		logic [31:0] len_out;
		logic [8:0]  freed_count;
	} out_item_t;

	typedef struct packed {
		logic       init;
		logic [3:0] qlog2;
	} cfg_ctl_t;

	// Largest k with 2^k <= v, used at elaboration only
	function automatic int flog2(input int v);
		int k;
		k = 0;
		for (int i = 1; i < 31; i++) begin
			if ((1 << i) <= v) begin
				k = i;
			end
		end
		return k;
	endfunction

endpackage

// ===== hw/rtl/svq_front.sv =====
// ----------------------------------------------------------------------------
// svq_front: input side of the descriptor manager
// Accepts words from the input stream, unpacks them and queues them for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
module svq_front
	import svq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// buf_addr, buf_len, buf_write, chain_length, chain_token, used_id, used_len
	input  logic [215:0] s_tdata,
	// opcode
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	output logic         item_valid,
	output in_item_t     item,
	input  logic         item_pop
);

	in_item_t   fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	in_item_t   in_word;
	logic       push;

	always_comb begin
		in_word.opcode       = s_tuser;
		in_word.buf_addr     = s_tdata[63:0];
		in_word.buf_len      = s_tdata[95:64];
		in_word.buf_write    = s_tdata[96];
		in_word.chain_length = s_tdata[105:97];
		in_word.chain_last   = s_tlast;
		in_word.chain_token  = s_tdata[169:106];
		in_word.used_id      = s_tdata[177:170];
		in_word.used_len     = s_tdata[209:178];
	end

	assign s_tready   = (cnt_q != 2'd2);
	assign push       = s_tvalid && s_tready;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, item_pop};
		end
	end

endmodule

// ===== hw/rtl/svq_back.sv =====
// ----------------------------------------------------------------------------
// svq_back: execution side of the descriptor manager
// Holds the descriptor link memory, token table and used ring, runs the
// add, post and get sequences and registers one result word at a time.
// ----------------------------------------------------------------------------
module svq_back
	import svq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_ctl_t     cfg,
	input  logic         item_valid,
	input  in_item_t     item,
	output logic         item_pop,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status, desc_index, desc_flags, avail_slot, avail_index, token_out,
	// len_out, freed_count
	output logic [143:0] m_tdata
);

	localparam int KMAX = (flog2(QUEUE_DEPTH) < 1) ? 1 : flog2(QUEUE_DEPTH);
	localparam int IW   = KMAX;
	localparam int CW   = KMAX + 1;
	localparam int NENT = 1 << KMAX;
	localparam int KRST = (int'(QLOG2_RESET) > KMAX) ? KMAX : int'(QLOG2_RESET);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_ADD2 = 3'd2;
	localparam logic [2:0] S_GET1 = 3'd3;
	localparam logic [2:0] S_WALK = 3'd4;

	// Link memory entry: next flag above the link index
	logic [IW:0]   lnk_mem [NENT];
	logic [63:0]   tok_mem [NENT];
	logic [39:0]   used_mem [NENT];

	logic          lnk_we, lnk_re, tok_we, tok_re, used_we, used_re;
	logic [IW-1:0] lnk_wa, lnk_ra, tok_wa, tok_ra, used_wa, used_ra;
	logic [IW:0]   lnk_wd, lnk_rd_q;
	logic [63:0]   tok_rd_q;
	logic [39:0]   used_wd, used_rd_q;

	logic [2:0]    state_q, state_d;
	logic [IW-1:0] clr_q, clr_d;
	logic [IW-1:0] fh_q, fh_d, head_q, head_d, prev_q, prev_d;
	logic [IW-1:0] idx_q, idx_d, cur_q, cur_d;
	logic [CW-1:0] fc_q, fc_d, cnt_q, cnt_d;
	logic [15:0]   avail_q, avail_d, uc_q, uc_d, luc_q, luc_d;
	logic          open_q, open_d, drop_q, drop_d, byp_q, byp_d;
	logic [8:0]    total_q, total_d, done_q, done_d;
	logic [31:0]   len_q, len_d;
	logic          out_valid_q, load;
	out_item_t     out_q, o;

	logic [3:0]    keff;
	logic [CW-1:0] q;
	logic [IW-1:0] m;
	logic          out_free;
	logic [IW-1:0] nxt;
	logic          closing;
	logic [CW:0]   fsum;

	always_comb begin
		keff = cfg.qlog2;
		if (keff == 4'd0) begin
			keff = 4'd1;
		end else if (int'(keff) > KMAX) begin
			keff = 4'(KMAX);
		end
	end

	assign q        = CW'(1) << keff;
	assign m        = IW'(q - CW'(1));
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q; clr_d = clr_q; fh_d = fh_q; head_d = head_q;
		prev_d = prev_q; idx_d = idx_q; cur_d = cur_q; fc_d = fc_q; cnt_d = cnt_q;
		avail_d = avail_q; uc_d = uc_q; luc_d = luc_q; open_d = open_q;
		drop_d = drop_q; byp_d = byp_q; total_d = total_q; done_d = done_q;
		len_d = len_q;
		lnk_we = 1'b0; lnk_wa = '0; lnk_wd = '0; lnk_re = 1'b0; lnk_ra = '0;
		tok_we = 1'b0; tok_wa = '0; tok_re = 1'b0; tok_ra = '0;
		used_we = 1'b0; used_wa = '0; used_wd = '0; used_re = 1'b0; used_ra = '0;
		load = 1'b0;
		o = '0;
		nxt = '0;
		closing = 1'b0;
		fsum = '0;
		case (state_q)
			S_CLR: begin
				lnk_we = 1'b1;
				lnk_wa = clr_q;
				lnk_wd = {1'b0, (clr_q + IW'(1)) & m};
				clr_d  = clr_q + IW'(1);
				if (clr_q == IW'(NENT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					case (item.opcode)
						OP_ADD: begin
							if (drop_q) begin
								if (out_free) begin
									load = 1'b1;
									o.status = ST_REJECT;
									if (item.chain_last) begin
										drop_d = 1'b0;
									end
								end
							end else if (!open_q && (item.chain_length == 9'd0 ||
								16'(item.chain_length) > 16'(fc_q))) begin
								if (out_free) begin
									load = 1'b1;
									o.status = ST_REJECT;
									drop_d = !item.chain_last;
								end
							end else begin
								if (!open_q) begin
									open_d  = 1'b1;
									total_d = item.chain_length;
									done_d  = 9'd0;
									head_d  = fh_q;
									tok_we  = 1'b1;
									tok_wa  = fh_q;
								end
								// Link the previous element of the chain to this one
								if (open_q && done_q != 9'd0) begin
									lnk_we = 1'b1;
									lnk_wa = prev_q;
									lnk_wd = {1'b1, fh_q};
								end
								byp_d   = open_q && done_q != 9'd0 && prev_q == fh_q;
								lnk_re  = 1'b1;
								lnk_ra  = fh_q;
								idx_d   = fh_q;
								state_d = S_ADD2;
							end
						end
						OP_POST: begin
							if (out_free) begin
								load    = 1'b1;
								used_we = 1'b1;
								used_wa = IW'(uc_q) & m;
								used_wd = {item.used_len, item.used_id};
								uc_d    = uc_q + 16'd1;
							end
						end
						OP_GET: begin
							if (luc_q == uc_q) begin
								if (out_free) begin
									load = 1'b1;
									o.status = ST_EMPTY;
								end
							end else begin
								used_re = 1'b1;
								used_ra = IW'(luc_q) & m;
								luc_d   = luc_q + 16'd1;
								state_d = S_GET1;
							end
						end
						default: begin
							load = out_free;
						end
					endcase
				end
			end
			S_ADD2: begin
				if (out_free) begin
					nxt     = byp_q ? idx_q : lnk_rd_q[IW-1:0];
					fh_d    = nxt & m;
					if (fc_q != '0) begin
						fc_d = fc_q - CW'(1);
					end
					done_d  = done_q + 9'd1;
					closing = item.chain_last || (done_q + 9'd1 >= total_q);
					lnk_we  = 1'b1;
					lnk_wa  = idx_q;
					lnk_wd  = {!closing, closing ? IW'(0) : nxt};
					prev_d  = idx_q;
					o.desc_index = 8'(idx_q);
					o.desc_flags = {item.buf_write, !closing};
					if (closing) begin
						o.avail_slot = 8'(IW'(avail_q) & m);
						avail_d = avail_q + 16'd1;
						open_d  = 1'b0;
					end
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_GET1: begin
				head_d  = IW'(used_rd_q[7:0]) & m;
				cur_d   = IW'(used_rd_q[7:0]) & m;
				len_d   = used_rd_q[39:8];
				tok_re  = 1'b1;
				tok_ra  = IW'(used_rd_q[7:0]) & m;
				lnk_re  = 1'b1;
				lnk_ra  = IW'(used_rd_q[7:0]) & m;
				cnt_d   = CW'(1);
				state_d = S_WALK;
			end
			S_WALK: begin
				if (lnk_rd_q[IW] && cnt_q < q) begin
					cur_d  = lnk_rd_q[IW-1:0] & m;
					lnk_re = 1'b1;
					lnk_ra = lnk_rd_q[IW-1:0] & m;
					cnt_d  = cnt_q + CW'(1);
				end else if (out_free) begin
					// Splice the freed chain in front of the free list
					lnk_we = 1'b1;
					lnk_wa = cur_q;
					lnk_wd = {lnk_rd_q[IW], fh_q};
					fh_d   = head_q;
					fsum   = {1'b0, fc_q} + {1'b0, cnt_q};
					fc_d   = (fsum > {1'b0, q}) ? q : CW'(fsum);
					o.token_out   = tok_rd_q;
					o.len_out     = len_q;
					o.freed_count = 9'(cnt_q);
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		o.avail_index = avail_d;
	end

	assign item_pop = load;

	always_ff @(posedge clk) begin
		if (lnk_we) begin
			lnk_mem[lnk_wa] <= lnk_wd;
		end
		if (lnk_re) begin
			lnk_rd_q <= lnk_mem[lnk_ra];
		end
		if (tok_we) begin
			tok_mem[tok_wa] <= item.chain_token;
		end
		if (tok_re) begin
			tok_rd_q <= tok_mem[tok_ra];
		end
		if (used_we) begin
			used_mem[used_wa] <= used_wd;
		end
		if (used_re) begin
			used_rd_q <= used_mem[used_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; clr_q <= '0; fh_q <= '0; fc_q <= CW'(1) << KRST;
			avail_q <= '0; uc_q <= '0; luc_q <= '0; open_q <= 1'b0; drop_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (cfg.init) begin
			state_q <= S_CLR; clr_q <= '0; fh_q <= '0;
			fc_q <= CW'(1) << (cfg.qlog2 == 4'd0 ? 4'd1 :
				(int'(cfg.qlog2) > KMAX ? 4'(KMAX) : cfg.qlog2));
			avail_q <= '0; uc_q <= '0; luc_q <= '0; open_q <= 1'b0; drop_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d; clr_q <= clr_d; fh_q <= fh_d; fc_q <= fc_d;
			avail_q <= avail_d; uc_q <= uc_d; luc_q <= luc_d; open_q <= open_d;
			drop_q <= drop_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		head_q <= head_d; prev_q <= prev_d; idx_q <= idx_d; cur_q <= cur_d;
		cnt_q <= cnt_d; byp_q <= byp_d; total_q <= total_d; len_q <= len_d;
		done_q <= cfg.init ? 9'd0 : done_d;
		if (load) begin
			out_q <= o;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.freed_count, out_q.len_out, out_q.token_out,
		out_q.avail_index, out_q.avail_slot, out_q.desc_flags, out_q.desc_index,
		out_q.status};

endmodule

// ===== hw/rtl/split_virtqueue_descriptor_manager.sv =====
// ----------------------------------------------------------------------------
// split_virtqueue_descriptor_manager: driver side of a split virtqueue
// Free list, avail publication and used-ring completion with an APB register.
// ----------------------------------------------------------------------------
// Post and refused or empty words are answered from the idle state, an add
// element passes through S_ADD2, and a get through S_GET1 and S_WALK, which
// follows the chain with one link memory read per descriptor. One result word
// per input word; words are handled one at a time, each finished before the next.
// Reset and every write of queue_size_log2 start a clearing pass over all
// 2^floor(log2(QUEUE_DEPTH)) link memory entries before work resumes.
module split_virtqueue_descriptor_manager
	import svq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// buf_addr, buf_len, buf_write, chain_length, chain_token, used_id, used_len
	input  logic [215:0] s_tdata,
	// opcode
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status, desc_index, desc_flags, avail_slot, avail_index, token_out,
	// len_out, freed_count
	output logic [143:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic       item_valid;
	in_item_t   item;
	logic       item_pop;
	logic [3:0] qlog2_q;
	logic       cfg_wr;
	cfg_ctl_t   cfg;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_QLOG2);
	assign prdata = (paddr[2] == REG_QLOG2) ? {28'd0, qlog2_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlog2_q <= QLOG2_RESET;
		end else if (cfg_wr) begin
			qlog2_q <= pwdata[3:0];
		end
	end

	// The new size takes effect as the clearing pass starts
	assign cfg = {cfg_wr, (cfg_wr ? pwdata[3:0] : qlog2_q)};

	svq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	svq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("invalid status code on result word");

	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[140:132] != 9'd0) |-> m_tdata[1:0] == ST_OK)
		else $error("descriptors freed on a failed word");

	a_flags_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[11:10] != 2'd0) |-> m_tdata[1:0] == ST_OK)
		else $error("descriptor flags on a failed word");

endmodule
